// ===== design/mutpf_pkg.sv =====
// Package: types, keyword tables and character codes for the token point finder.
`timescale 1ns / 1ps

package mutpf_pkg;

  typedef logic [7:0] byte_t;

  // Parser modes, one-hot.
  typedef enum logic [6:0] {
    MODE_OUTSIDE      = 7'b0000001,
    MODE_TAG          = 7'b0000010,
    MODE_CLOSE_TAG    = 7'b0000100,
    MODE_ATTR         = 7'b0001000,
    MODE_BEFORE_VALUE = 7'b0010000,
    MODE_QUOTED       = 7'b0100000,
    MODE_QUOTED_QUERY = 7'b1000000
  } mode_e;

  localparam byte_t CH_LT    = 8'h3C;
  localparam byte_t CH_GT    = 8'h3E;
  localparam byte_t CH_SLASH = 8'h2F;
  localparam byte_t CH_QUERY = 8'h3F;
  localparam byte_t CH_QUOTE = 8'h22;
  localparam byte_t CH_EQ    = 8'h3D;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_CR    = 8'h0D;

  localparam int unsigned KW_TEMPLATE_LEN = 15;
  localparam int unsigned KW_MEDIA_LEN    = 5;
  localparam int unsigned KW_INIT_LEN     = 14;

  typedef struct packed {
    byte_t in_byte;
  } in_item_t;

  typedef struct packed {
    byte_t      out_byte;
    logic       insert_before;
    logic       value_has_query;
    byte_t      value_last_char;
  } out_item_t;

  // Result of the parser for the byte being stepped.
  typedef struct packed {
    logic  insert_before;
    logic  value_has_query;
    byte_t value_last_char;
  } parse_res_t;

  function automatic logic is_blank(input byte_t c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // "SegmentTemplate"
  function automatic byte_t template_char(input logic [3:0] idx);
    byte_t ch;
    unique case (idx)
      4'd0:    ch = 8'h53;
      4'd1:    ch = 8'h65;
      4'd2:    ch = 8'h67;
      4'd3:    ch = 8'h6D;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h54;
      4'd8:    ch = 8'h65;
      4'd9:    ch = 8'h6D;
      4'd10:   ch = 8'h70;
      4'd11:   ch = 8'h6C;
      4'd12:   ch = 8'h61;
      4'd13:   ch = 8'h74;
      4'd14:   ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "media"
  function automatic byte_t media_char(input logic [3:0] idx);
    byte_t ch;
    unique case (idx)
      4'd0:    ch = 8'h6D;
      4'd1:    ch = 8'h65;
      4'd2:    ch = 8'h64;
      4'd3:    ch = 8'h69;
      4'd4:    ch = 8'h61;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "initialization"
  function automatic byte_t init_char(input logic [3:0] idx);
    byte_t ch;
    unique case (idx)
      4'd0:    ch = 8'h69;
      4'd1:    ch = 8'h6E;
      4'd2:    ch = 8'h69;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h69;
      4'd5:    ch = 8'h61;
      4'd6:    ch = 8'h6C;
      4'd7:    ch = 8'h69;
      4'd8:    ch = 8'h7A;
      4'd9:    ch = 8'h61;
      4'd10:   ch = 8'h74;
      4'd11:   ch = 8'h69;
      4'd12:   ch = 8'h6F;
      4'd13:   ch = 8'h6E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/mutpf_stream_if.sv =====
// Interface: valid/ready stream channel carrying one payload item.
`timescale 1ns / 1ps

interface mutpf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/mutpf_parser.sv =====
// Tag and attribute parser state with incremental keyword matching.
`timescale 1ns / 1ps

module mutpf_parser
  import mutpf_pkg::*;
#(
  parameter int unsigned TAG_NAME_MAX  = 32,
  parameter int unsigned ATTR_NAME_MAX = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  byte_t      byte_i,
  output parse_res_t res_o
);

  localparam int unsigned TagLenW  = $clog2(TAG_NAME_MAX + 1);
  localparam int unsigned AttrLenW = $clog2(ATTR_NAME_MAX + 1);

  mode_e               mode_q, mode_d;
  logic [TagLenW-1:0]  tag_len_q, tag_len_d;
  logic [AttrLenW-1:0] attr_len_q, attr_len_d;
  logic                tmpl_ok_q, tmpl_ok_d;
  logic                media_ok_q, media_ok_d;
  logic                init_ok_q, init_ok_d;
  byte_t               prev_q, prev_d;

  logic tag_room, attr_room, tmpl_hit, attr_hit;

  // The stored names are never kept: each keyword carries a flag that says
  // whether the name written so far is still a prefix of it.
  assign tag_room  = tag_len_q < TagLenW'(TAG_NAME_MAX);
  assign attr_room = attr_len_q < AttrLenW'(ATTR_NAME_MAX);
  assign tmpl_hit  = tmpl_ok_q && (tag_len_q == TagLenW'(KW_TEMPLATE_LEN));
  assign attr_hit  = (media_ok_q && (attr_len_q == AttrLenW'(KW_MEDIA_LEN))) ||
                     (init_ok_q && (attr_len_q == AttrLenW'(KW_INIT_LEN)));

  always_comb begin
    mode_d     = mode_q;
    tag_len_d  = tag_len_q;
    attr_len_d = attr_len_q;
    tmpl_ok_d  = tmpl_ok_q;
    media_ok_d = media_ok_q;
    init_ok_d  = init_ok_q;
    prev_d     = prev_q;
    res_o      = '0;

    unique case (mode_q)
      MODE_TAG, MODE_CLOSE_TAG: begin
        if (is_blank(byte_i)) begin
          if (tag_len_q != '0) begin
            mode_d     = MODE_ATTR;
            attr_len_d = '0;
            media_ok_d = 1'b1;
            init_ok_d  = 1'b1;
          end
        end else if (byte_i == CH_GT) begin
          mode_d = MODE_OUTSIDE;
        end else if (byte_i == CH_SLASH && tag_len_q == '0) begin
          mode_d = MODE_CLOSE_TAG;
        end else if (tag_room) begin
          tmpl_ok_d = tmpl_ok_q && (tag_len_q < TagLenW'(KW_TEMPLATE_LEN)) &&
                      (byte_i == template_char(tag_len_q[3:0]));
          tag_len_d = tag_len_q + 1'b1;
        end
      end
      MODE_ATTR: begin
        if (is_blank(byte_i)) begin
          mode_d = mode_q;
        end else if (byte_i == CH_EQ) begin
          mode_d = MODE_BEFORE_VALUE;
        end else if (byte_i == CH_GT) begin
          mode_d = MODE_OUTSIDE;
        end else if (attr_room) begin
          media_ok_d = media_ok_q && (attr_len_q < AttrLenW'(KW_MEDIA_LEN)) &&
                       (byte_i == media_char(attr_len_q[3:0]));
          init_ok_d  = init_ok_q && (attr_len_q < AttrLenW'(KW_INIT_LEN)) &&
                       (byte_i == init_char(attr_len_q[3:0]));
          attr_len_d = attr_len_q + 1'b1;
        end
      end
      MODE_BEFORE_VALUE: begin
        if (byte_i == CH_QUOTE) begin
          mode_d = MODE_QUOTED;
          prev_d = '0;
        end
      end
      MODE_QUOTED, MODE_QUOTED_QUERY: begin
        if (byte_i != CH_QUOTE) begin
          prev_d = byte_i;
          if (byte_i == CH_QUERY) begin
            mode_d = MODE_QUOTED_QUERY;
          end
        end else begin
          if (tmpl_hit && attr_hit) begin
            res_o.insert_before   = 1'b1;
            res_o.value_has_query = (mode_q == MODE_QUOTED_QUERY);
            res_o.value_last_char = prev_q;
          end
          mode_d     = MODE_ATTR;
          attr_len_d = '0;
          media_ok_d = 1'b1;
          init_ok_d  = 1'b1;
        end
      end
      default: begin
        if (byte_i == CH_LT) begin
          mode_d    = MODE_TAG;
          tag_len_d = '0;
          tmpl_ok_d = 1'b1;
        end else begin
          mode_d = MODE_OUTSIDE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_OUTSIDE;
      tag_len_q  <= '0;
      attr_len_q <= '0;
      tmpl_ok_q  <= 1'b1;
      media_ok_q <= 1'b1;
      init_ok_q  <= 1'b1;
      prev_q     <= '0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      tag_len_q  <= tag_len_d;
      attr_len_q <= attr_len_d;
      tmpl_ok_q  <= tmpl_ok_d;
      media_ok_q <= media_ok_d;
      init_ok_q  <= init_ok_d;
      prev_q     <= prev_d;
    end
  end

endmodule

// ===== design/manifest_url_token_point_finder.sv =====
// Top level: input register, parser and result register of the token point finder.
//
// The block takes one manifest byte per item on in_i and gives one result
// item per byte on out_o: the byte itself, and on the closing quote of a
// media or initialization value inside a SegmentTemplate tag a flag that a
// token is to be inserted before it, together with whether the value held
// a '?' and the last byte of the value.
// Both channels are valid/ready; an item moves at an edge where both are
// high. A byte is captured in the input register, stepped through the
// parser and written to the result register once the result register is
// empty or out_o takes its item, and out_o offers it from there. Throughput is
// one byte per cycle while the receiver does not stall, set by the single
// parser step between the two registers.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more byte; after that in_i.ready drops
// until out_o moves again. Nothing is lost or repeated.
// Reset empties both registers and puts the parser outside any tag with
// empty tag and attribute names.
`timescale 1ns / 1ps

module manifest_url_token_point_finder
  import mutpf_pkg::*;
#(
  parameter int unsigned TAG_NAME_MAX  = 32,
  parameter int unsigned ATTR_NAME_MAX = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mutpf_stream_if.sink          in_i,
  mutpf_stream_if.source        out_o
);

  logic       in_vld_q, out_vld_q;
  byte_t      in_byte_q;
  out_item_t  out_item_q, out_item_d;
  logic       advance;
  parse_res_t res;

  assign advance     = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || advance;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_item_q;

  mutpf_parser #(
    .TAG_NAME_MAX  (TAG_NAME_MAX),
    .ATTR_NAME_MAX (ATTR_NAME_MAX)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_comb begin
    out_item_d.out_byte        = in_byte_q;
    out_item_d.insert_before   = res.insert_before;
    out_item_d.value_has_query = res.value_has_query;
    out_item_d.value_last_char = res.value_last_char;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data.in_byte;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

endmodule
